// ===== hw/rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared sizes, state type and controller-datapath command/status structs.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int MaxEntries = 16;
   localparam int IdxW       = $clog2(MaxEntries);
   localparam int CntW       = $clog2(MaxEntries + 1);
   localparam int KeyW       = 32;
   localparam int UseW       = 32;
   localparam logic [CntW-1:0] CapacityReset = CntW'(MaxEntries);
   localparam logic [KeyW-1:0] MissData      = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVICT,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   // Commands issued by the controller to the datapath.
   typedef struct packed {
      logic load_req;   // capture the request and clear scan results
      logic scan_step;  // examine the entry under the scan index
      logic evict;      // drop the chosen victim
      logic update;     // apply the hit update or the insert
      logic respond;    // drive the response strobe
   } cmd_type;

   // Status reported back to the controller.
   typedef struct packed {
      logic scan_last;  // the scan index is on the last entry
      logic need_evict; // a put of a new key finds the store full
   } stat_type;

endpackage

// ===== hw/rtl/lfu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences one request through scan, optional eviction, update and response.
// ----------------------------------------------------------------------------
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            cmd.evict = stat.need_evict;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/lfu_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry store, serial key and victim scan, and the entry update logic.
// ----------------------------------------------------------------------------
module lfu_datapath
   import lfu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output stat_type        stat,
   input  logic [CntW-1:0] capacity,
   input  logic            req_type,
   input  logic [KeyW-1:0] req_key,
   input  logic [KeyW-1:0] req_value,
   output logic            rsp_valid,
   output logic            rsp_hit,
   output logic [KeyW-1:0] rsp_read_data
);

   logic            valid_ff [MaxEntries];
   logic [KeyW-1:0] key_ff   [MaxEntries];
   logic [KeyW-1:0] value_ff [MaxEntries];
   logic [UseW-1:0] use_ff   [MaxEntries];
   logic [IdxW-1:0] age_ff   [MaxEntries];
   logic [CntW-1:0] occ_ff;

   logic            put_ff;
   logic [KeyW-1:0] rkey_ff, rval_ff;
   logic [IdxW-1:0] idx_ff;
   logic            found_ff, vict_ok_ff, free_ok_ff;
   logic [IdxW-1:0] found_ff_idx, vict_ff, free_ff;
   logic [IdxW-1:0] vict_age_ff;
   logic [UseW-1:0] vict_use_ff;
   logic            rsp_valid_ff, rsp_hit_ff;
   logic [KeyW-1:0] rsp_data_ff;

   logic [CntW-1:0] cap_eff;
   logic            better;
   logic            do_ins;
   logic [IdxW-1:0] ins_slot;

   assign cap_eff = (capacity > CntW'(MaxEntries)) ? CntW'(MaxEntries) : capacity;
   assign better  = !vict_ok_ff || (use_ff[idx_ff] < vict_use_ff) ||
                    (use_ff[idx_ff] == vict_use_ff && age_ff[idx_ff] > vict_age_ff);
   assign stat.scan_last  = (idx_ff == IdxW'(MaxEntries - 1));
   assign stat.need_evict = put_ff && !found_ff && (cap_eff != '0) &&
                            (occ_ff >= cap_eff) && vict_ok_ff;
   // With a nonzero capacity a put of a new key always finds a slot: the first
   // free one, or else the victim slot, which the eviction has freed.
   assign do_ins   = put_ff && !found_ff && (cap_eff != '0);
   assign ins_slot = free_ok_ff ? free_ff : vict_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         put_ff  <= req_type;
         rkey_ff <= req_key;
         rval_ff <= req_value;
      end
      if (cmd.scan_step) begin
         if (valid_ff[idx_ff]) begin
            if (!found_ff && key_ff[idx_ff] == rkey_ff) begin
               found_ff_idx <= idx_ff;
            end
            if (better) begin
               vict_ff     <= idx_ff;
               vict_use_ff <= use_ff[idx_ff];
               vict_age_ff <= age_ff[idx_ff];
            end
         end else if (!free_ok_ff) begin
            free_ff <= idx_ff;
         end
      end
      if (cmd.update) begin
         rsp_hit_ff  <= found_ff;
         rsp_data_ff <= put_ff ? '0 : (found_ff ? value_ff[found_ff_idx] : MissData);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         vict_ok_ff   <= 1'b0;
         free_ok_ff   <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MaxEntries; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.load_req) begin
            idx_ff     <= '0;
            found_ff   <= 1'b0;
            vict_ok_ff <= 1'b0;
            free_ok_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (valid_ff[idx_ff]) begin
               if (key_ff[idx_ff] == rkey_ff) begin
                  found_ff <= 1'b1;
               end
               vict_ok_ff <= 1'b1;
            end else begin
               free_ok_ff <= 1'b1;
            end
         end
         if (cmd.evict) begin
            valid_ff[vict_ff] <= 1'b0;
            occ_ff            <= occ_ff - 1'b1;
            for (int i = 0; i < MaxEntries; i++) begin
               if (valid_ff[i] && age_ff[i] > vict_age_ff) begin
                  age_ff[i] <= age_ff[i] - 1'b1;
               end
            end
         end
         if (cmd.update) begin
            if (found_ff && (!put_ff || cap_eff != '0)) begin
               // Touch: younger entries age by one, the hit entry becomes newest.
               for (int i = 0; i < MaxEntries; i++) begin
                  if (valid_ff[i] && age_ff[i] < age_ff[found_ff_idx]) begin
                     age_ff[i] <= age_ff[i] + 1'b1;
                  end
               end
               age_ff[found_ff_idx] <= '0;
               if (use_ff[found_ff_idx] != '1) begin
                  use_ff[found_ff_idx] <= use_ff[found_ff_idx] + 1'b1;
               end
               if (put_ff) begin
                  value_ff[found_ff_idx] <= rval_ff;
               end
            end else if (do_ins) begin
               for (int i = 0; i < MaxEntries; i++) begin
                  if (valid_ff[i]) begin
                     age_ff[i] <= age_ff[i] + 1'b1;
                  end
               end
               valid_ff[ins_slot] <= 1'b1;
               key_ff[ins_slot]   <= rkey_ff;
               value_ff[ins_slot] <= rval_ff;
               use_ff[ins_slot]   <= UseW'(1);
               age_ff[ins_slot]   <= '0;
               occ_ff             <= occ_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ===== hw/rtl/lfu_cache_replacement_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break, top level
// A request is scanned one entry per cycle over all MaxEntries entries, then goes
// through the evict, update and respond phases; busy is high until the strobe
// cycle, so a new request is taken only once the last one is through.
// The response is shown for one cycle and cannot be stalled by the receiver.
// Synchronous reset empties the store and sets capacity to 16.
// ----------------------------------------------------------------------------
module lfu_cache_replacement_top
   import lfu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // Request channel.
   input  logic            start,
   output logic            busy,
   input  logic            req_req_type,
   input  logic [KeyW-1:0] req_key,
   input  logic [KeyW-1:0] req_value,
   // Response channel.
   output logic            rsp_valid,
   output logic            rsp_hit,
   output logic [KeyW-1:0] rsp_read_data,
   // Capacity register write channel.
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [CntW-1:0] csr_data
);

   cmd_type         cmd;
   stat_type        stat;
   logic [CntW-1:0] capacity_ff;

   // The capacity register accepts writes at any time.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapacityReset;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   // The controller walks each request through its phases.
   lfu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath holds the entries and performs the scan and update.
   lfu_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .capacity      (capacity_ff),
      .req_type      (req_req_type),
      .req_key       (req_key),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_read_data (rsp_read_data)
   );

endmodule

// ===== hw/rtl/lfu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache port checker
// Checks request and response sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module lfu_checker
   import lfu_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_valid,
   input logic [KeyW-1:0] rsp_read_data
);

   // An accepted request makes the block busy.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a request");

   // A response strobe lasts one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // The response is shown once the block is free again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   // The read data is fully defined while the strobe is high.
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_read_data))
      else $error("unknown read data on a response");

endmodule

bind lfu_cache_replacement_top lfu_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_read_data (rsp_read_data)
);
